FILE: rtl/core/ssd3_pkg.sv
// ----------------------------------------------------------------------------
// ssd3_pkg: shared constants and types for the segment distance block
// Default field widths, result range, queue sizing and status struct.
// ----------------------------------------------------------------------------
package ssd3_pkg;

  localparam int COORD_BITS      = 16;
  localparam int PARAM_FRAC_BITS = 16;
  localparam int DIST_FRAC_BITS  = 8;
  localparam int DIST_W          = 25;
  // Queue depth between front and back; keep it a power of two.
  localparam int QUEUE_DEPTH     = 4;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // Width of one queue entry: sN, sD, tN, tD and the nine direction terms.
  function automatic int queue_w(input int coord_bits);
    int dw;
    int nw;
    dw = coord_bits + 1;
    nw = 2 * (2 * dw + 2) + 1;
    queue_w = 4 * nw + 9 * dw;
  endfunction

endpackage

FILE: rtl/core/ssd3_mul.sv
// ----------------------------------------------------------------------------
// ssd3_mul: two-stage signed multiplier
// Split both operands in halves, register four partial products, then sum.
// ----------------------------------------------------------------------------
module ssd3_mul #(
  parameter int AW = 36,
  parameter int BW = 36
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic signed [AW-1:0]        a_i,
  input  logic signed [BW-1:0]        b_i,
  output logic signed [AW+BW-1:0]     p_o
);

  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic signed [AH+BH-1:0] hh_q;
  logic signed [AH+BL:0]   hl_q;
  logic signed [AL+BH:0]   lh_q;
  logic        [AL+BL-1:0] ll_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hh_q <= $signed(a_i[AW-1:AL]) * $signed(b_i[BW-1:BL]);
      hl_q <= $signed(a_i[AW-1:AL]) * $signed({1'b0, b_i[BL-1:0]});
      lh_q <= $signed({1'b0, a_i[AL-1:0]}) * $signed(b_i[BW-1:BL]);
      ll_q <= a_i[AL-1:0] * b_i[BL-1:0];
      p_o  <= $signed((PW'(hh_q) << (AL + BL)) + (PW'(hl_q) << AL) +
                      (PW'(lh_q) << BL) + PW'(ll_q));
    end
  end

endmodule

FILE: rtl/core/ssd3_fifo.sv
// ----------------------------------------------------------------------------
// ssd3_fifo: short queue between front and back
// Flop-based circular buffer; depth must be a power of two.
// ----------------------------------------------------------------------------
module ssd3_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = ssd3_pkg::QUEUE_DEPTH
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [W-1:0]            in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [W-1:0]            out_data_o,
  output ssd3_pkg::queue_status_t status_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [AW:0]   cnt_q;
  logic          push, pop;

  assign in_ready_o  = (cnt_q != (AW+1)'(DEPTH));
  assign out_valid_o = (cnt_q != '0);
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;
  assign out_data_o  = mem_q[rd_q];

  assign status_o.full  = !in_ready_o;
  assign status_o.empty = !out_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + AW'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (AW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (AW+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: rtl/core/ssd3_front.sv
// ----------------------------------------------------------------------------
// ssd3_front: direction vectors, dot products and case classification
// Eight stages from coordinates to clamped sN/sD and tN/tD.
// ----------------------------------------------------------------------------
module ssd3_front #(
  parameter int COORD_BITS = ssd3_pkg::COORD_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [12*COORD_BITS-1:0]                 in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [ssd3_pkg::queue_w(COORD_BITS)-1:0] out_data_o
);

  localparam int DW    = COORD_BITS + 1;
  localparam int DOTW  = 2 * DW + 2;
  localparam int NW    = 2 * DOTW + 1;
  localparam int UVW_W = 9 * DW;
  localparam int NST   = 8;
  localparam int A_I = 0, B_I = 1, C_I = 2, D_I = 3, E_I = 4;

  function automatic logic signed [DOTW-1:0] dot_f(input logic [5*DOTW-1:0] x,
                                                   input int i);
    dot_f = $signed(x[i*DOTW +: DOTW]);
  endfunction

  logic           en;
  logic [NST-1:0] vld_q;

  assign en          = !vld_q[NST-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // Stage 1: u = a_end - a_start, v = b_end - b_start, w = a_start - b_start
  logic signed [COORD_BITS-1:0] crd [12];
  logic signed [DW-1:0] u1_q [3], v1_q [3], w1_q [3];

  always_comb begin
    for (int k = 0; k < 12; k++) begin
      crd[k] = $signed(in_data_i[k*COORD_BITS +: COORD_BITS]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        u1_q[k] <= DW'(crd[3+k]) - DW'(crd[k]);
        v1_q[k] <= DW'(crd[9+k]) - DW'(crd[6+k]);
        w1_q[k] <= DW'(crd[k]) - DW'(crd[6+k]);
      end
    end
  end

  // Stage 2: per-axis products
  logic signed [2*DW-1:0] uu2_q [3], uv2_q [3], vv2_q [3], uw2_q [3], vw2_q [3];
  logic [UVW_W-1:0] uvw_q [2:NST];
  logic [UVW_W-1:0] uvw_pk;

  assign uvw_pk = {w1_q[2], w1_q[1], w1_q[0], v1_q[2], v1_q[1], v1_q[0],
                   u1_q[2], u1_q[1], u1_q[0]};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        uu2_q[k] <= u1_q[k] * u1_q[k];
        uv2_q[k] <= u1_q[k] * v1_q[k];
        vv2_q[k] <= v1_q[k] * v1_q[k];
        uw2_q[k] <= u1_q[k] * w1_q[k];
        vw2_q[k] <= v1_q[k] * w1_q[k];
      end
      uvw_q[2] <= uvw_pk;
      for (int s = 3; s <= NST; s++) begin
        uvw_q[s] <= uvw_q[s-1];
      end
    end
  end

  // Stage 3: a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
  logic signed [DOTW-1:0] a3_q, b3_q, c3_q, d3_q, e3_q;
  logic [5*DOTW-1:0] dot_q [4:NST];

  always_ff @(posedge clk_i) begin
    if (en) begin
      a3_q <= DOTW'(uu2_q[0]) + DOTW'(uu2_q[1]) + DOTW'(uu2_q[2]);
      b3_q <= DOTW'(uv2_q[0]) + DOTW'(uv2_q[1]) + DOTW'(uv2_q[2]);
      c3_q <= DOTW'(vv2_q[0]) + DOTW'(vv2_q[1]) + DOTW'(vv2_q[2]);
      d3_q <= DOTW'(uw2_q[0]) + DOTW'(uw2_q[1]) + DOTW'(uw2_q[2]);
      e3_q <= DOTW'(vw2_q[0]) + DOTW'(vw2_q[1]) + DOTW'(vw2_q[2]);
      dot_q[4] <= {e3_q, d3_q, c3_q, b3_q, a3_q};
      for (int s = 5; s <= NST; s++) begin
        dot_q[s] <= dot_q[s-1];
      end
    end
  end

  // Stages 4-5: cross products for D, sN and tN
  logic signed [2*DOTW-1:0] ac5, bb5, be5, cd5, ae5, bd5;

  ssd3_mul #(.AW(DOTW), .BW(DOTW)) u_mul_ac (.clk_i, .en_i(en), .a_i(a3_q), .b_i(c3_q),
                                             .p_o(ac5));
  ssd3_mul #(.AW(DOTW), .BW(DOTW)) u_mul_bb (.clk_i, .en_i(en), .a_i(b3_q), .b_i(b3_q),
                                             .p_o(bb5));
  ssd3_mul #(.AW(DOTW), .BW(DOTW)) u_mul_be (.clk_i, .en_i(en), .a_i(b3_q), .b_i(e3_q),
                                             .p_o(be5));
  ssd3_mul #(.AW(DOTW), .BW(DOTW)) u_mul_cd (.clk_i, .en_i(en), .a_i(c3_q), .b_i(d3_q),
                                             .p_o(cd5));
  ssd3_mul #(.AW(DOTW), .BW(DOTW)) u_mul_ae (.clk_i, .en_i(en), .a_i(a3_q), .b_i(e3_q),
                                             .p_o(ae5));
  ssd3_mul #(.AW(DOTW), .BW(DOTW)) u_mul_bd (.clk_i, .en_i(en), .a_i(b3_q), .b_i(d3_q),
                                             .p_o(bd5));

  // Stage 6: D, unclamped sN and tN
  logic signed [NW-1:0] den6_q, sn6_q, tn6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      den6_q <= NW'(ac5) - NW'(bb5);
      sn6_q  <= NW'(be5) - NW'(cd5);
      tn6_q  <= NW'(ae5) - NW'(bd5);
    end
  end

  // Stage 7: parallel case and clamp of s
  logic signed [DOTW-1:0] b6, c6, e6;
  logic signed [DOTW:0]   eb6;
  logic signed [NW-1:0]   sn7_d, sd7_d, tn7_d, td7_d;
  logic signed [NW-1:0]   sn7_q, sd7_q, tn7_q, td7_q;

  assign b6  = dot_f(dot_q[6], B_I);
  assign c6  = dot_f(dot_q[6], C_I);
  assign e6  = dot_f(dot_q[6], E_I);
  assign eb6 = (DOTW+1)'(e6) + (DOTW+1)'(b6);

  always_comb begin
    sn7_d = sn6_q;
    sd7_d = den6_q;
    tn7_d = tn6_q;
    td7_d = den6_q;
    if (den6_q[NW-1] || (den6_q == '0)) begin
      sn7_d = '0;
      sd7_d = NW'(1);
      tn7_d = NW'(e6);
      td7_d = NW'(c6);
    end else if (sn6_q[NW-1]) begin
      sn7_d = '0;
      tn7_d = NW'(e6);
      td7_d = NW'(c6);
    end else if (den6_q < sn6_q) begin
      sn7_d = den6_q;
      tn7_d = NW'(eb6);
      td7_d = NW'(c6);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn7_q <= sn7_d;
      sd7_q <= sd7_d;
      tn7_q <= tn7_d;
      td7_q <= td7_d;
    end
  end

  // Stage 8: clamp of t, recompute s against the clamped t
  logic signed [DOTW-1:0] a7, b7, d7;
  logic signed [DOTW:0]   alt;
  logic signed [NW-1:0]   sn8_d, sd8_d, tn8_d, td8_d;
  logic signed [NW-1:0]   sn8_q, sd8_q, tn8_q, td8_q;

  assign a7 = dot_f(dot_q[7], A_I);
  assign b7 = dot_f(dot_q[7], B_I);
  assign d7 = dot_f(dot_q[7], D_I);

  always_comb begin
    sn8_d = sn7_q;
    sd8_d = sd7_q;
    tn8_d = tn7_q;
    td8_d = td7_q;
    alt   = '0;
    if (tn7_q[NW-1] || (td7_q < tn7_q)) begin
      if (tn7_q[NW-1]) begin
        tn8_d = '0;
        alt   = -(DOTW+1)'(d7);
      end else begin
        tn8_d = td7_q;
        alt   = (DOTW+1)'(b7) - (DOTW+1)'(d7);
      end
      if (alt[DOTW]) begin
        sn8_d = '0;
      end else if (alt > (DOTW+1)'(a7)) begin
        sn8_d = sd7_q;
      end else begin
        sn8_d = NW'(alt);
        sd8_d = NW'(a7);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sn8_q <= sn8_d;
      sd8_q <= sd8_d;
      tn8_q <= tn8_d;
      td8_q <= td8_d;
    end
  end

  assign out_data_o = {uvw_q[NST], td8_q, tn8_q, sd8_q, sn8_q};

endmodule

FILE: rtl/core/ssd3_back.sv
// ----------------------------------------------------------------------------
// ssd3_back: fractions, closest-point difference and square root
// Bit-per-stage dividers for sc and tc, squared length, bit-per-stage root.
// ----------------------------------------------------------------------------
module ssd3_back #(
  parameter int COORD_BITS      = ssd3_pkg::COORD_BITS,
  parameter int PARAM_FRAC_BITS = ssd3_pkg::PARAM_FRAC_BITS,
  parameter int DIST_FRAC_BITS  = ssd3_pkg::DIST_FRAC_BITS
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [ssd3_pkg::queue_w(COORD_BITS)-1:0] in_data_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic [ssd3_pkg::DIST_W-1:0]              distance_o
);

  localparam int DW    = COORD_BITS + 1;
  localparam int DOTW  = 2 * DW + 2;
  localparam int NW    = 2 * DOTW + 1;
  localparam int UVW_W = 9 * DW;
  localparam int P     = PARAM_FRAC_BITS;
  localparam int PW    = COORD_BITS + P + 3;
  localparam int SQW   = 2 * PW + 2;
  localparam int SHL   = (DIST_FRAC_BITS > P) ? 2 * (DIST_FRAC_BITS - P) : 0;
  localparam int SHR   = (DIST_FRAC_BITS <= P) ? 2 * (P - DIST_FRAC_BITS) : 0;
  localparam int SW    = SQW + SHL - SHR;
  localparam int SQ_W  = SW + (SW % 2);
  localparam int RB    = SQ_W / 2;
  localparam int NV    = P + RB + 8;
  localparam int DIST_W = ssd3_pkg::DIST_W;

  typedef enum logic [1:0] {FRAC_ZERO, FRAC_ONE, FRAC_DIV} frac_mode_e;

  function automatic frac_mode_e mode_f(input logic signed [NW-1:0] num,
                                        input logic signed [NW-1:0] den);
    if (num[NW-1] || (num == '0) || den[NW-1] || (den == '0)) begin
      mode_f = FRAC_ZERO;
    end else if (!(num < den)) begin
      mode_f = FRAC_ONE;
    end else begin
      mode_f = FRAC_DIV;
    end
  endfunction

  function automatic logic [P:0] frac_f(input frac_mode_e m, input logic [P-1:0] q);
    unique case (m)
      FRAC_ZERO: frac_f = '0;
      FRAC_ONE:  frac_f = (P+1)'(1) << P;
      default:   frac_f = {1'b0, q};
    endcase
  endfunction

  logic          en;
  logic [NV-1:0] vld_q;

  assign en          = !vld_q[NV-1] || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = vld_q[NV-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NV-2:0], in_valid_i};
    end
  end

  // Load: classify each fraction as zero, one or a true quotient
  logic signed [NW-1:0] sn_in, sd_in, tn_in, td_in;

  assign sn_in = $signed(in_data_i[0*NW +: NW]);
  assign sd_in = $signed(in_data_i[1*NW +: NW]);
  assign tn_in = $signed(in_data_i[2*NW +: NW]);
  assign td_in = $signed(in_data_i[3*NW +: NW]);

  logic [NW-1:0]    srem_q [P+1], sden_q [P+1], trem_q [P+1], tden_q [P+1];
  logic [P-1:0]     squo_q [P+1], tquo_q [P+1];
  frac_mode_e       smode_q [P+1], tmode_q [P+1];
  logic [UVW_W-1:0] duvw_q [P+1];

  logic [NW-1:0] sdbl [1:P], tdbl [1:P];
  logic [P:1]    sge, tge;

  // Restoring division, one quotient bit per stage
  always_comb begin
    for (int j = 1; j <= P; j++) begin
      sdbl[j] = {srem_q[j-1][NW-2:0], 1'b0};
      tdbl[j] = {trem_q[j-1][NW-2:0], 1'b0};
      sge[j]  = (sdbl[j] >= sden_q[j-1]);
      tge[j]  = (tdbl[j] >= tden_q[j-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      srem_q[0]  <= sn_in;
      sden_q[0]  <= sd_in;
      smode_q[0] <= mode_f(sn_in, sd_in);
      squo_q[0]  <= '0;
      trem_q[0]  <= tn_in;
      tden_q[0]  <= td_in;
      tmode_q[0] <= mode_f(tn_in, td_in);
      tquo_q[0]  <= '0;
      duvw_q[0]  <= in_data_i[4*NW +: UVW_W];
      for (int j = 1; j <= P; j++) begin
        srem_q[j]  <= sge[j] ? sdbl[j] - sden_q[j-1] : sdbl[j];
        trem_q[j]  <= tge[j] ? tdbl[j] - tden_q[j-1] : tdbl[j];
        squo_q[j]  <= {squo_q[j-1][P-2:0], sge[j]};
        tquo_q[j]  <= {tquo_q[j-1][P-2:0], tge[j]};
        sden_q[j]  <= sden_q[j-1];
        tden_q[j]  <= tden_q[j-1];
        smode_q[j] <= smode_q[j-1];
        tmode_q[j] <= tmode_q[j-1];
        duvw_q[j]  <= duvw_q[j-1];
      end
    end
  end

  // Fractions sc, tc in 0 .. 2^P
  logic [P:0]       sf_q, tf_q;
  logic [UVW_W-1:0] fuvw_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sf_q   <= frac_f(smode_q[P], squo_q[P]);
      tf_q   <= frac_f(tmode_q[P], tquo_q[P]);
      fuvw_q <= duvw_q[P];
    end
  end

  // sc*u, tc*v and w scaled to the fraction grid
  logic signed [PW-1:0] su_q [3], tv_q [3], ws_q [3], p_q [3];
  logic signed [DW-1:0] uf [3], vf [3], wf [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      uf[k] = $signed(fuvw_q[k*DW +: DW]);
      vf[k] = $signed(fuvw_q[(3+k)*DW +: DW]);
      wf[k] = $signed(fuvw_q[(6+k)*DW +: DW]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        su_q[k] <= PW'(uf[k]) * $signed({1'b0, sf_q});
        tv_q[k] <= PW'(vf[k]) * $signed({1'b0, tf_q});
        ws_q[k] <= PW'(wf[k]) <<< P;
        p_q[k]  <= ws_q[k] + su_q[k] - tv_q[k];
      end
    end
  end

  // Square each axis of dP
  logic signed [2*PW-1:0] sq [3];

  for (genvar k = 0; k < 3; k++) begin : g_sq
    ssd3_mul #(.AW(PW), .BW(PW)) u_mul_sq (
      .clk_i,
      .en_i (en),
      .a_i  (p_q[k]),
      .b_i  (p_q[k]),
      .p_o  (sq[k])
    );
  end

  // Sum of squares, rescaled to the output fraction bits
  logic [SQW-1:0]     acc_sum;
  logic [SQW+SHL-1:0] acc_sh;
  logic [SQ_W-1:0]    acc_q;

  assign acc_sum = SQW'(sq[0][2*PW-1:0]) + SQW'(sq[1][2*PW-1:0]) +
                   SQW'(sq[2][2*PW-1:0]);
  assign acc_sh  = (SQW+SHL)'(acc_sum) << SHL;

  always_ff @(posedge clk_i) begin
    if (en) begin
      acc_q <= SQ_W'(acc_sh >> SHR);
    end
  end

  // Integer square root, one result bit per stage
  logic [SQ_W-1:0] num_q [RB], res_q [RB];
  logic [SQ_W-1:0] nin [RB], rin [RB], rbit [RB], tsq [RB];
  logic [RB-1:0]   rge;

  always_comb begin
    for (int i = 0; i < RB; i++) begin
      if (i == 0) begin
        nin[i] = acc_q;
        rin[i] = '0;
      end else begin
        nin[i] = num_q[i-1];
        rin[i] = res_q[i-1];
      end
      rbit[i] = SQ_W'(1) << (2 * (RB - 1 - i));
      tsq[i]  = rin[i] + rbit[i];
      rge[i]  = (nin[i] >= tsq[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < RB; i++) begin
        num_q[i] <= rge[i] ? nin[i] - tsq[i] : nin[i];
        res_q[i] <= rge[i] ? (rin[i] >> 1) + rbit[i] : rin[i] >> 1;
      end
    end
  end

  // Saturate into the output register
  logic [SQ_W+DIST_W-1:0] root_ext;
  logic [DIST_W-1:0]      dist_q;

  assign root_ext = (SQ_W+DIST_W)'(res_q[RB-1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= (root_ext > (SQ_W+DIST_W)'(ssd3_pkg::DIST_MAX)) ?
                ssd3_pkg::DIST_MAX : root_ext[DIST_W-1:0];
    end
  end

  assign distance_o = dist_q;

endmodule

FILE: rtl/core/segment_segment_distance_3d.sv
// ----------------------------------------------------------------------------
// segment_segment_distance_3d: minimum distance between two 3D segments
// Path: front pipeline, then the queue, then the back pipeline to the output register.
// Throughput: one transaction per cycle if output is ready; fully staged dividers and root.
// Reset: asynchronous active low; clears valid flags and queue pointers only.
// ----------------------------------------------------------------------------
module segment_segment_distance_3d #(
  parameter int COORD_BITS      = ssd3_pkg::COORD_BITS,
  parameter int PARAM_FRAC_BITS = ssd3_pkg::PARAM_FRAC_BITS,
  parameter int DIST_FRAC_BITS  = ssd3_pkg::DIST_FRAC_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // tdata, low bit up: a_start_x, a_start_y, a_start_z, a_end_x, a_end_y,
  // a_end_z, b_start_x, b_start_y, b_start_z, b_end_x, b_end_y, b_end_z
  input  logic [((12*COORD_BITS+7)/8)*8-1:0]  s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // tdata, low bit up: distance (25 bits, 8 fraction bits by default), zero pad
  output logic [((ssd3_pkg::DIST_W+7)/8)*8-1:0] m_axis_tdata_o
);

  localparam int QW    = ssd3_pkg::queue_w(COORD_BITS);
  localparam int OUT_W = ((ssd3_pkg::DIST_W + 7) / 8) * 8;

  // Front to queue
  logic          front_valid, front_ready;
  logic [QW-1:0] front_data;

  // Queue to back
  logic          back_valid, back_ready;
  logic [QW-1:0] back_data;

  ssd3_pkg::queue_status_t     q_status;
  logic [ssd3_pkg::DIST_W-1:0] distance;

  // Front: take a transaction every cycle unless the queue backs up
  ssd3_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (s_axis_tdata_i[12*COORD_BITS-1:0]),
    .out_valid_o (front_valid),
    .out_ready_i (front_ready),
    .out_data_o  (front_data)
  );

  // Queue: absorb short output stalls so the front keeps streaming
  ssd3_fifo #(
    .W     (QW),
    .DEPTH (ssd3_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .in_valid_i  (front_valid),
    .in_ready_o  (front_ready),
    .in_data_i   (front_data),
    .out_valid_o (back_valid),
    .out_ready_i (back_ready),
    .out_data_o  (back_data),
    .status_o    (q_status)
  );

  // Back: divide, form dP, square, root; its last stage is the output register
  ssd3_back #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .DIST_FRAC_BITS  (DIST_FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .in_valid_i  (back_valid),
    .in_ready_o  (back_ready),
    .in_data_i   (back_data),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .distance_o  (distance)
  );

  // Pad the result to whole bytes
  assign m_axis_tdata_o = OUT_W'(distance);

`ifndef ASSERT_OFF
  // Front only stalls input when the queue is full
  a_in_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> q_status.full)
    else $error("input stalled while queue has room");

  // Queue cannot be full and empty together
  a_queue_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  // A held result freezes the back pipeline
  a_out_stall_holds_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !back_ready)
    else $error("back advanced under output stall");
`endif

endmodule
